// File: rtl/gbbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbbr_pkg;

    // Access status codes returned with every result item.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_READONLY = 2'd3
    } status_t;

    // Register index (offset bits [7:2]) inside the window.
    localparam logic [5:0] REG_DIR = 6'd0;
    localparam logic [5:0] REG_OUT = 6'd1;
    localparam logic [5:0] REG_IN  = 6'd2;
    localparam logic [5:0] REG_SET = 6'd3;
    localparam logic [5:0] REG_CLR = 6'd4;
    localparam logic [5:0] REG_TGL = 6'd5;

    localparam logic [5:0] PINS_USED_RESET = 6'd32;

    // One buffered bus access.
    typedef struct packed {
        logic        mode;
        logic [7:0]  offset;
        logic [7:0]  write_byte;
        logic [31:0] pin_levels;
    } access_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  read_data;
        status_t     access_status;
        logic [31:0] direction_mask;
        logic [31:0] output_levels;
    } result_t;

    // Implemented-pin mask; counts of 32 and above enable every pin.
    function automatic logic [31:0] pin_mask(input logic [5:0] count);
        logic [31:0] m;
        m = 32'h0;
        if (count[5]) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = (32'h1 << count[4:0]) - 32'h1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gbbr_access.sv
`timescale 1ns / 1ps
`default_nettype none

module gbbr_access
    import gbbr_pkg::*;
#(
    parameter int WINDOW_BYTES       = 24,
    parameter int INVALID_READ_VALUE = 255
) (
    input  var access_t     acc,
    input  var logic [31:0] mask,
    input  var logic [31:0] dir_cur,
    input  var logic [31:0] out_cur,
    output var logic [31:0] dir_new,
    output var logic [31:0] out_new,
    output var result_t     res
);

    localparam logic [8:0] WINDOW_END = 9'(WINDOW_BYTES);
    localparam logic [7:0] BAD_BYTE   = 8'(INVALID_READ_VALUE);

    logic [5:0]  reg_idx;
    logic [4:0]  shift;
    logic [31:0] dir_vis;
    logic [31:0] out_vis;
    logic [31:0] part;
    logic [31:0] keep;
    logic [31:0] rd_word;
    logic [31:0] rd_shifted;
    logic [31:0] dir_merge;
    logic [31:0] out_merge;
    logic        known;
    status_t     status;

    assign reg_idx    = acc.offset[7:2];
    assign shift      = {acc.offset[1:0], 3'b000};
    assign dir_vis    = dir_cur & mask;
    assign out_vis    = out_cur & mask;
    assign part       = ({24'h0, acc.write_byte} << shift) & mask;
    assign keep       = ~(32'h0000_00FF << shift);
    assign rd_shifted = rd_word >> shift;

    always_comb begin
        rd_word   = 32'h0;
        known     = 1'b1;
        dir_merge = dir_vis;
        out_merge = out_vis;
        status    = ST_OK;
        case (reg_idx)
            REG_DIR: begin
                rd_word   = dir_vis;
                dir_merge = (dir_vis & keep) | part;
            end
            REG_OUT: begin
                rd_word   = out_vis;
                out_merge = (out_vis & keep) | part;
            end
            REG_IN: begin
                rd_word = (acc.pin_levels & mask & ~dir_vis) | (out_vis & dir_vis);
                if (acc.mode) begin
                    status = ST_READONLY;
                end
            end
            REG_SET: out_merge = out_vis | part;
            REG_CLR: out_merge = out_vis & ~part;
            REG_TGL: out_merge = out_vis ^ part;
            default: begin
                known  = 1'b0;
                status = ST_UNKNOWN;
            end
        endcase
        // Outside the window nothing changes.
        if ({1'b0, acc.offset} >= WINDOW_END) begin
            known     = 1'b0;
            status    = ST_RANGE;
            dir_merge = dir_vis;
            out_merge = out_vis;
        end
    end

    // Hidden pins keep their bits; only the write path moves state.
    assign dir_new = acc.mode ? ((dir_cur & ~mask) | (dir_merge & mask)) : dir_cur;
    assign out_new = acc.mode ? ((out_cur & ~mask) | (out_merge & mask)) : out_cur;

    always_comb begin
        res.access_status  = status;
        res.direction_mask = dir_new & mask;
        res.output_levels  = out_new & mask;
        if (acc.mode) begin
            res.read_data = 8'h00;
        end else if (known) begin
            res.read_data = rd_shifted[7:0];
        end else begin
            res.read_data = BAD_BYTE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gpio_byte_bus_registers_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_valid/s_ready    mode, offset, write_byte, pin_levels
// m_*       out  m_valid/m_ready    read_data, access_status, direction_mask, output_levels
// cfg_*     in   cfg_we (no wait)   cfg_wdata = number of implemented pins
//
// Two register stages: an input register and a result register. An item
// accepted on s_* enters the input register, moves to the result register
// and is offered on m_* from there; while m_ready does not stall, one item
// per cycle is sustained. The direction and output registers update when the
// item leaves the input register. Reset is synchronous, active low: state and
// both valid flags clear, the pin count returns to 32. A stall on m_ready
// holds the result; the input register still takes one more item behind it.

module gpio_byte_bus_registers_unit
    import gbbr_pkg::*;
#(
    parameter int WINDOW_BYTES       = 24,
    parameter int INVALID_READ_VALUE = 255
) (
    input  var logic        aclk,
    input  var logic        aresetn,

    input  var logic        cfg_we,
    input  var logic [5:0]  cfg_wdata,

    input  var logic        s_valid,
    output var logic        s_ready,
    input  var logic        s_mode,
    input  var logic [7:0]  s_offset,
    input  var logic [7:0]  s_write_byte,
    input  var logic [31:0] s_pin_levels,

    output var logic        m_valid,
    input  var logic        m_ready,
    output var logic [7:0]  m_read_data,
    output var logic [1:0]  m_access_status,
    output var logic [31:0] m_direction_mask,
    output var logic [31:0] m_output_levels
);

    logic [5:0]  pins_used_reg;
    logic [31:0] direction_reg;
    logic [31:0] direction_next;
    logic [31:0] output_reg;
    logic [31:0] output_next;
    logic [31:0] mask;

    access_t     acc_reg;
    logic        acc_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        res_valid_reg;
    logic        advance;

    // Move the buffered item into the result register when it is free.
    assign advance = acc_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !acc_valid_reg || advance;
    assign mask    = pin_mask(pins_used_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pins_used_reg <= PINS_USED_RESET;
        end else if (cfg_we) begin
            pins_used_reg <= cfg_wdata;
        end
    end

    // Input register: payload without reset, valid flag with.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
        end else if (s_ready) begin
            acc_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            acc_reg.mode       <= s_mode;
            acc_reg.offset     <= s_offset;
            acc_reg.write_byte <= s_write_byte;
            acc_reg.pin_levels <= s_pin_levels;
        end
    end

    gbbr_access #(
        .WINDOW_BYTES      (WINDOW_BYTES),
        .INVALID_READ_VALUE(INVALID_READ_VALUE)
    ) u_access (
        .acc    (acc_reg),
        .mask   (mask),
        .dir_cur(direction_reg),
        .out_cur(output_reg),
        .dir_new(direction_next),
        .out_new(output_next),
        .res    (res_next)
    );

    // Commit register state and the result together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 32'h0;
            output_reg    <= 32'h0;
            res_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                direction_reg <= direction_next;
                output_reg    <= output_next;
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = res_valid_reg;
    assign m_read_data      = res_reg.read_data;
    assign m_access_status  = res_reg.access_status;
    assign m_direction_mask = res_reg.direction_mask;
    assign m_output_levels  = res_reg.output_levels;

    // Results never show pins above the configured count.
    a_mask_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_direction_mask | m_output_levels) & ~mask) == 32'h0)
        else $error("result shows pins above the pin count");

    // Read-only status comes only from writes, which return zero.
    a_ro_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_access_status == ST_READONLY) |-> m_read_data == 8'h00)
        else $error("read-only status with nonzero read data");

    // Register state moves only when an item advances.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(direction_reg) && $stable(output_reg)))
        else $error("GPIO state changed without an item");

    // Input side stalls only with both stages full and output blocked.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (acc_valid_reg && res_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// File: test/gpio_byte_bus_registers_unit_tb.sv
`timescale 1ns / 1ps

module gpio_byte_bus_registers_unit_tb;
    import gbbr_pkg::*;

    localparam int          WINDOW_BYTES = 24;
    localparam logic [7:0]  INVALID_BYTE = 8'hFF;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    // Bus access kinds on s_mode.
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [7:0]  s_offset;
    logic [7:0]  s_write_byte;
    logic [31:0] s_pin_levels;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [7:0]  m_read_data;
    logic [1:0]  m_access_status;
    logic [31:0] m_direction_mask;
    logic [31:0] m_output_levels;

    // Shadow copy of the GPIO state, advanced once per accepted item.
    logic [31:0] dir_bits;
    logic [31:0] out_bits;
    logic [5:0]  pins_used_q;

    // Predicted replies, oldest first.
    result_t     gpio_replies_due[$];

    int unsigned cycle_count = 0;
    int          fault_count = 0;

    // Idle control: quiet turns off all idling for the final stretch, the calm
    // counters give stretches without idling during the rest of the run.
    bit          quiet   = 1'b0;
    int          tx_calm = 0;
    int          rx_calm = 0;
    int          rx_hold = 0;

    gpio_byte_bus_registers_unit #(
        .WINDOW_BYTES       (WINDOW_BYTES),
        .INVALID_READ_VALUE (INVALID_BYTE)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_offset         (s_offset),
        .s_write_byte     (s_write_byte),
        .s_pin_levels     (s_pin_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_access_status  (m_access_status),
        .m_direction_mask (m_direction_mask),
        .m_output_levels  (m_output_levels)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Work out the reply to one bus access and advance the shadow registers.
    function automatic result_t gpio_access_effect(input access_t acc);
        result_t     r;
        logic [31:0] live;
        logic [31:0] dir_v;
        logic [31:0] out_v;
        logic [31:0] sel;
        logic [31:0] part;
        logic [31:0] keep;
        logic [31:0] nxt_dir;
        logic [31:0] nxt_out;
        logic [4:0]  sh;
        // Counts of 32 and above enable every pin; zero enables none.
        live    = (pins_used_q > 6'd31) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << pins_used_q);
        dir_v   = dir_bits & live;
        out_v   = out_bits & live;
        nxt_dir = dir_v;
        nxt_out = out_v;
        sh      = {acc.offset[1:0], 3'b000};
        sel     = 32'h0;
        r.read_data     = 8'h00;
        r.access_status = ST_OK;
        if (acc.offset >= WINDOW_BYTES) begin
            // Outside the window: nothing changes, reads give the invalid byte.
            r.access_status = ST_RANGE;
            if (acc.mode == ACC_READ) begin
                r.read_data = INVALID_BYTE;
            end
        end else if (acc.mode == ACC_READ) begin
            case (acc.offset[7:2])
                REG_DIR: sel = dir_v;
                REG_OUT: sel = out_v;
                // Input pins show the injected level, output pins the driven one.
                REG_IN:  sel = (acc.pin_levels & live & ~dir_v) | (out_v & dir_v);
                REG_SET, REG_CLR, REG_TGL: sel = 32'h0;
                default: r.access_status = ST_UNKNOWN;
            endcase
            r.read_data = (r.access_status == ST_UNKNOWN) ? INVALID_BYTE : sel[sh +: 8];
        end else begin
            part = ({24'h0, acc.write_byte} << sh) & live;
            keep = ~(32'h0000_00FF << sh);
            case (acc.offset[7:2])
                REG_DIR: nxt_dir = (dir_v & keep) | part;
                REG_OUT: nxt_out = (out_v & keep) | part;
                REG_SET: nxt_out = out_v | part;
                REG_CLR: nxt_out = out_v & ~part;
                REG_TGL: nxt_out = out_v ^ part;
                REG_IN:  r.access_status = ST_READONLY;
                default: r.access_status = ST_UNKNOWN;
            endcase
        end
        // Bits above the pin count hold their old value.
        dir_bits = (dir_bits & ~live) | (nxt_dir & live);
        out_bits = (out_bits & ~live) | (nxt_out & live);
        r.direction_mask = dir_bits & live;
        r.output_levels  = out_bits & live;
        return r;
    endfunction

    // Offer one item, wait for the handshake, then record its reply.
    // Valid stays high on return so back-to-back items follow without a gap.
    task automatic bus_access(input logic mode, input logic [7:0] offset,
                              input logic [7:0] data, input logic [31:0] levels);
        access_t acc;
        acc = '{mode: mode, offset: offset, write_byte: data, pin_levels: levels};
        if (tx_calm > 0) begin
            tx_calm--;
        end else if (!quiet && $urandom_range(0, 99) == 0) begin
            tx_calm = $urandom_range(20, 100);
        end
        // Occasionally drop valid for a burst before the item.
        if (!quiet && tx_calm == 0 && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= acc.mode;
        s_offset     <= acc.offset;
        s_write_byte <= acc.write_byte;
        s_pin_levels <= acc.pin_levels;
        do @(posedge aclk); while (!s_ready);
        gpio_replies_due.push_back(gpio_access_effect(acc));
    endtask

    // Drop valid and hold off until every predicted reply has been seen.
    task automatic wait_replies_drained();
        s_valid <= 1'b0;
        while (gpio_replies_due.size() != 0) @(posedge aclk);
    endtask

    // Reprogram the pin count; only done with the block idle.
    task automatic set_pins_used(input logic [5:0] count);
        wait_replies_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pins_used_q = count;
    endtask

    // Mostly in-window accesses so the registers see real traffic; the rest
    // sweeps the whole offset range.
    task automatic send_random_access();
        logic [7:0]  offset;
        logic [31:0] levels;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            offset = {6'($urandom_range(REG_DIR, REG_TGL)), 2'($urandom_range(0, 3))};
        end else begin
            offset = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            levels = 32'h0;
        end else if (pick == 1) begin
            levels = 32'hFFFF_FFFF;
        end else begin
            levels = $urandom;
        end
        bus_access(1'($urandom_range(0, 1)), offset, 8'($urandom), levels);
    endtask

    // Reset contents: all inputs, so input data mirrors the pins.
    task automatic test_reset_state();
        bus_access(ACC_READ, {REG_DIR, 2'd0}, 8'h00, 32'h0);
        bus_access(ACC_READ, {REG_IN, 2'd3}, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Byte lanes of direction and output data merge into the word.
    task automatic test_byte_merge();
        bus_access(ACC_WRITE, {REG_DIR, 2'd0}, 8'hA5, 32'h0);
        bus_access(ACC_WRITE, {REG_DIR, 2'd3}, 8'hFF, 32'h0);
        bus_access(ACC_WRITE, {REG_OUT, 2'd0}, 8'hFF, 32'h0);
        bus_access(ACC_WRITE, {REG_OUT, 2'd2}, 8'h3C, 32'h0);
        bus_access(ACC_READ,  {REG_DIR, 2'd3}, 8'h00, 32'h0);
        bus_access(ACC_READ,  {REG_OUT, 2'd2}, 8'h00, 32'h0);
    endtask

    // Set, clear and toggle act on output data and read back as zero.
    task automatic test_set_clear_toggle();
        bus_access(ACC_WRITE, {REG_SET, 2'd1}, 8'hFF, 32'h0);
        bus_access(ACC_WRITE, {REG_CLR, 2'd0}, 8'h0F, 32'h0);
        bus_access(ACC_WRITE, {REG_TGL, 2'd3}, 8'hFF, 32'h0);
        bus_access(ACC_READ,  {REG_SET, 2'd0}, 8'h00, 32'h0);
        bus_access(ACC_READ,  {REG_CLR, 2'd1}, 8'h00, 32'h0);
        bus_access(ACC_READ,  {REG_TGL, 2'd2}, 8'h00, 32'h0);
        bus_access(ACC_READ,  {REG_OUT, 2'd1}, 8'h00, 32'h0);
    endtask

    // Input data mixes pin levels and driven levels; writes are refused.
    task automatic test_input_data();
        bus_access(ACC_READ,  {REG_IN, 2'd0}, 8'h00, 32'h0);
        bus_access(ACC_READ,  {REG_IN, 2'd0}, 8'h00, 32'hFFFF_FFFF);
        bus_access(ACC_WRITE, {REG_IN, 2'd1}, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Offsets past the window flag range and leave the state alone.
    task automatic test_out_of_window();
        bus_access(ACC_READ,  8'(WINDOW_BYTES), 8'h00, 32'h0);
        bus_access(ACC_READ,  8'hFF, 8'h00, 32'hFFFF_FFFF);
        bus_access(ACC_WRITE, 8'd200, 8'hFF, 32'h0);
    endtask

    // Narrow pin counts hide upper bits without losing them; zero masks all,
    // oversized counts behave as thirty-two.
    task automatic test_pins_used_limits();
        set_pins_used(6'd5);
        bus_access(ACC_WRITE, {REG_OUT, 2'd0}, 8'h00, 32'h0);
        set_pins_used(6'd32);
        bus_access(ACC_READ,  {REG_OUT, 2'd0}, 8'h00, 32'h0);
        set_pins_used(6'd0);
        bus_access(ACC_WRITE, {REG_DIR, 2'd0}, 8'hFF, 32'h0);
        bus_access(ACC_READ,  {REG_DIR, 2'd0}, 8'h00, 32'hFFFF_FFFF);
        set_pins_used(6'd63);
        bus_access(ACC_READ,  {REG_DIR, 2'd3}, 8'h00, 32'h0);
    endtask

    // Random traffic across a spread of pin counts, extremes included.
    task automatic test_random_traffic();
        logic [5:0] counts [10];
        counts = '{6'd32, 6'd1, 6'd31, 6'd0, 6'd63, 6'd33, 6'd32, 6'd8, 6'd20, 6'd32};
        counts[7] = 6'($urandom_range(2, 30));
        counts[8] = 6'($urandom_range(0, 63));
        foreach (counts[i]) begin
            set_pins_used(counts[i]);
            repeat (160) send_random_access();
        end
    endtask

    // Last stretch with no idling on either side: full-rate traffic.
    task automatic test_back_to_back();
        set_pins_used(6'($urandom_range(1, 32)));
        quiet = 1'b1;
        repeat (100) send_random_access();
    endtask

    // Compare one reply field; keep going after a miss.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Check every reply item against the oldest prediction.
    always @(posedge aclk) begin : reply_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (gpio_replies_due.size() == 0) begin
                $display("%0t: reply item with none expected: expected nothing, actual %h %0d %h %h",
                         $time, m_read_data, m_access_status, m_direction_mask,
                         m_output_levels);
                fault_count++;
            end else begin
                want = gpio_replies_due.pop_front();
                check_field("read_data", want.read_data, m_read_data);
                check_field("access_status", want.access_status, m_access_status);
                check_field("direction_mask", want.direction_mask, m_direction_mask);
                check_field("output_levels", want.output_levels, m_output_levels);
            end
        end
    end

    // Receiver backpressure: random stall bursts with calm stretches, and none at
    // all once quiet is set.
    always @(posedge aclk) begin
        if (rx_calm > 0) begin
            rx_calm--;
        end else if (!quiet && $urandom_range(0, 199) == 0) begin
            rx_calm = $urandom_range(30, 150);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (!quiet && rx_calm == 0 && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gpio_byte_bus_registers_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= PINS_USED_RESET;
        s_valid      <= 1'b0;
        s_mode       <= ACC_READ;
        s_offset     <= 8'h00;
        s_write_byte <= 8'h00;
        s_pin_levels <= 32'h0;
        dir_bits     = 32'h0;
        out_bits     = 32'h0;
        pins_used_q  = PINS_USED_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_byte_merge();
        test_set_clear_toggle();
        test_input_data();
        test_out_of_window();
        test_pins_used_limits();
        test_random_traffic();
        test_back_to_back();

        // Drain, then keep watching for anything stray to show up.
        wait_replies_drained();
        repeat (8) @(posedge aclk);
        if (fault_count == 0) begin
            $display("gpio_byte_bus_registers_unit_tb: clean");
        end else begin
            $display("gpio_byte_bus_registers_unit_tb: errors");
        end
        $finish;
    end

endmodule
